### hw/rtl/breakpoint_match_unit_top_defines.svh
// assertion macros for the breakpoint match unit
// expects clk and arst_n in the scope of every use
`ifndef BREAKPOINT_MATCH_UNIT_TOP_DEFINES_SVH
`define BREAKPOINT_MATCH_UNIT_TOP_DEFINES_SVH

// same-cycle implication
`define BMU_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bmu assertion failed");

// next-cycle implication
`define BMU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bmu assertion failed");

`endif

### hw/rtl/bmu_pkg.sv
// shared types and constants of the breakpoint match unit
// no dependencies
`timescale 1ns / 1ps

package bmu_pkg;

	localparam int BREAKPOINTS_DEF = 16;
	localparam int ADDR_W          = 16;
	localparam int SKIP_W          = 16;
	localparam int CMD_W           = 2;
	localparam int STATUS_W        = 2;
	localparam int ECNT_W          = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_FETCH  = 2'd0,
		CMD_SET    = 2'd1,
		CMD_UNSET  = 2'd2,
		CMD_RESUME = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_DUP       = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// request token walking down the cell chain
	typedef struct packed {
		logic              vld;
		cmd_t              cmd;
		logic [ADDR_W-1:0] addr;
		logic              found;
	} tok_t;

	// control from the commit logic to every cell
	typedef struct packed {
		logic              adv;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
	} ctl_t;

endpackage

### hw/rtl/bmu_cell.sv
// one table cell: holds one breakpoint, compares the passing token
// depends on bmu_pkg
`timescale 1ns / 1ps

module bmu_cell #(
	parameter int BREAKPOINTS = bmu_pkg::BREAKPOINTS_DEF,
	parameter int INDEX       = 0,
	localparam int CW         = $clog2(BREAKPOINTS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bmu_pkg::ctl_t             ctl,
	input  logic [CW-1:0]             count,
	input  bmu_pkg::tok_t             tok_in,
	output bmu_pkg::tok_t             tok_out,
	input  logic [bmu_pkg::ADDR_W-1:0] next_entry,
	output logic [bmu_pkg::ADDR_W-1:0] entry
);

	bmu_pkg::tok_t              tok_q;
	bmu_pkg::tok_t              tok_d;
	logic [bmu_pkg::ADDR_W-1:0] entry_q;
	logic                       in_use;
	logic                       match;
	logic                       shift;

	always_comb begin
		in_use      = CW'(INDEX) < count;
		match       = tok_in.vld && in_use && (entry_q == tok_in.addr);
		tok_d       = tok_in;
		tok_d.found = tok_in.found | match;
		// token sits at the next cell with a match at or before this one
		shift       = ctl.adv && tok_q.vld && tok_q.found &&
		              (tok_q.cmd == bmu_pkg::CMD_UNSET);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (ctl.adv) begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en && (count == CW'(INDEX))) begin
			entry_q <= ctl.wr_addr;
		end else if (shift) begin
			entry_q <= next_entry;
		end
	end

	assign tok_out = tok_q;
	assign entry   = entry_q;

endmodule

### hw/rtl/bmu_ctrl.sv
// request intake, commit of state updates and response register
// depends on bmu_pkg and breakpoint_match_unit_top_defines.svh
`timescale 1ns / 1ps
`include "breakpoint_match_unit_top_defines.svh"

module bmu_ctrl #(
	parameter int BREAKPOINTS = bmu_pkg::BREAKPOINTS_DEF,
	localparam int CW         = $clog2(BREAKPOINTS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [bmu_pkg::CMD_W-1:0]     cmd,
	input  logic [bmu_pkg::ADDR_W-1:0]    address,
	input  logic [bmu_pkg::SKIP_W-1:0]    skip_count,
	output bmu_pkg::tok_t                 tok_first,
	input  bmu_pkg::tok_t                 tok_end,
	output bmu_pkg::ctl_t                 ctl,
	output logic [CW-1:0]                 count,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          halted,
	output logic                          hit,
	output logic [bmu_pkg::STATUS_W-1:0]  status,
	output logic [bmu_pkg::ECNT_W-1:0]    entry_count
);

	logic                          busy_q;
	logic [CW-1:0]                 cnt_q;
	logic [bmu_pkg::SKIP_W-1:0]    skip_q;
	logic                          halt_q;
	logic [bmu_pkg::SKIP_W-1:0]    skip_in_q;
	logic                          rsp_vld_q;
	logic                          halt_rsp_q;
	logic                          hit_q;
	bmu_pkg::status_t              status_q;
	logic [bmu_pkg::ECNT_W-1:0]    ecnt_q;

	logic                          commit;
	logic                          accept;
	logic                          hit_d;
	bmu_pkg::status_t              status_d;
	logic [CW-1:0]                 cnt_d;
	logic                          halt_d;
	logic [bmu_pkg::SKIP_W-1:0]    skip_d;
	logic                          wr_ok;
	logic [CW+bmu_pkg::ECNT_W-1:0] ecnt_ext;

	always_comb begin
		commit    = tok_end.vld && (!rsp_vld_q || !rsp_stall);
		// first cell must compare against the committed table
		req_stall = busy_q;
		accept    = req_valid && !req_stall;

		tok_first.vld   = accept;
		tok_first.cmd   = bmu_pkg::cmd_t'(cmd);
		tok_first.addr  = address;
		tok_first.found = 1'b0;
	end

	always_comb begin
		hit_d    = 1'b0;
		status_d = bmu_pkg::ST_OK;
		cnt_d    = cnt_q;
		halt_d   = halt_q;
		skip_d   = skip_q;
		wr_ok    = 1'b0;
		unique case (tok_end.cmd)
			bmu_pkg::CMD_FETCH: begin
				if (tok_end.found) begin
					hit_d = 1'b1;
					if (!halt_q) begin
						if (skip_q == '0) begin
							halt_d = 1'b1;
						end else begin
							skip_d = skip_q - bmu_pkg::SKIP_W'(1);
						end
					end
				end
			end
			bmu_pkg::CMD_SET: begin
				if (cnt_q >= CW'(BREAKPOINTS)) begin
					status_d = bmu_pkg::ST_FULL;
				end else if (tok_end.found) begin
					status_d = bmu_pkg::ST_DUP;
				end else begin
					wr_ok = 1'b1;
					cnt_d = cnt_q + CW'(1);
				end
			end
			bmu_pkg::CMD_UNSET: begin
				if (!tok_end.found) begin
					status_d = bmu_pkg::ST_NOT_FOUND;
				end else begin
					cnt_d = cnt_q - CW'(1);
				end
			end
			bmu_pkg::CMD_RESUME: begin
				halt_d = 1'b0;
				skip_d = skip_in_q;
			end
		endcase
		ecnt_ext = {{bmu_pkg::ECNT_W{1'b0}}, cnt_d};

		ctl.adv     = !tok_end.vld || commit;
		ctl.wr_en   = commit && wr_ok;
		ctl.wr_addr = tok_end.addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			skip_q    <= '0;
			halt_q    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				cnt_q     <= cnt_d;
				skip_q    <= skip_d;
				halt_q    <= halt_d;
				rsp_vld_q <= 1'b1;
			end else if (rsp_vld_q && !rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			skip_in_q <= skip_count;
		end
		if (commit) begin
			halt_rsp_q <= halt_d;
			hit_q      <= hit_d;
			status_q   <= status_d;
			ecnt_q     <= ecnt_ext[bmu_pkg::ECNT_W-1:0];
		end
	end

	assign count       = cnt_q;
	assign rsp_valid   = rsp_vld_q;
	assign halted      = halt_rsp_q;
	assign hit         = hit_q;
	assign status      = status_q;
	assign entry_count = ecnt_q;

	`BMU_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CW'(BREAKPOINTS))
	`BMU_ASSERT_IMPL(a_tok_busy, tok_end.vld, busy_q)
	`BMU_ASSERT_NEXT(a_unset_dec, commit && tok_end.cmd == bmu_pkg::CMD_UNSET && tok_end.found, cnt_q == $past(cnt_q) - CW'(1))
	`BMU_ASSERT_NEXT(a_halt_cause, !halt_q && !(commit && tok_end.cmd == bmu_pkg::CMD_FETCH && tok_end.found && skip_q == '0), !halt_q)
	`BMU_ASSERT_NEXT(a_commit_rsp, commit, rsp_vld_q)

endmodule

### hw/rtl/breakpoint_match_unit_top.sv
// top level of the breakpoint match unit: cell chain plus commit control
// depends on bmu_pkg, bmu_cell, bmu_ctrl
//
// channel  | handshake            | fields
// request  | req_valid/req_stall  | cmd, address, skip_count
// response | rsp_valid/rsp_stall  | halted, hit, status, entry_count
//
// a request's token walks the chain one cell per cycle unless rsp_stall holds the chain, then commits
// the response is registered when the token commits at the chain end
// the next request is taken the cycle after the last one commits
// unset closes the gap by shifting later entries down as the token passes
// reset clears count, skip counter, internal halt flag and all control; table entries and response fields are not reset
// rsp_stall holds the token at the chain end until the response register frees up
`timescale 1ns / 1ps

module breakpoint_match_unit_top #(
	parameter int BREAKPOINTS = bmu_pkg::BREAKPOINTS_DEF,
	localparam int CW         = $clog2(BREAKPOINTS + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [bmu_pkg::CMD_W-1:0]    cmd,
	input  logic [bmu_pkg::ADDR_W-1:0]   address,
	input  logic [bmu_pkg::SKIP_W-1:0]   skip_count,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic                         halted,
	output logic                         hit,
	output logic [bmu_pkg::STATUS_W-1:0] status,
	output logic [bmu_pkg::ECNT_W-1:0]   entry_count
);

	bmu_pkg::tok_t              tok_c [0:BREAKPOINTS];
	logic [bmu_pkg::ADDR_W-1:0] ent   [0:BREAKPOINTS-1];
	bmu_pkg::ctl_t              ctl;
	logic [CW-1:0]              count;

	bmu_ctrl #(
		.BREAKPOINTS(BREAKPOINTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.cmd         (cmd),
		.address     (address),
		.skip_count  (skip_count),
		.tok_first   (tok_c[0]),
		.tok_end     (tok_c[BREAKPOINTS]),
		.ctl         (ctl),
		.count       (count),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.halted      (halted),
		.hit         (hit),
		.status      (status),
		.entry_count (entry_count)
	);

	for (genvar i = 0; i < BREAKPOINTS; i++) begin : g_cell
		logic [bmu_pkg::ADDR_W-1:0] nxt;
		if (i == BREAKPOINTS - 1) begin : g_last
			assign nxt = ent[i];
		end else begin : g_mid
			assign nxt = ent[i+1];
		end

		bmu_cell #(
			.BREAKPOINTS(BREAKPOINTS),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.count      (count),
			.tok_in     (tok_c[i]),
			.tok_out    (tok_c[i+1]),
			.next_entry (nxt),
			.entry      (ent[i])
		);
	end

endmodule
